[src/mlcd_pkg.sv]
// Shared types, constants and a helper function for the magic/length/checksum deframer.
`default_nettype none
package mlcd_pkg;

  localparam int BUFFER_BYTES = 512;
  localparam int MAX_PAYLOAD = 256;

  localparam int BYTE_W = 8;
  localparam int MAGIC_W = 16;
  localparam int LEN_W = 9;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int POS_W = $clog2(BUFFER_BYTES + 1);
  localparam int CMP_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 2;

  localparam int HDR_BYTES = 4;
  localparam int FRAME_OVERHEAD = 6;

  localparam logic [BYTE_W-1:0] MOD_SUM = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd1;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 9'd256;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NONE   = 2'd0,
    STATUS_GOOD   = 2'd1,
    STATUS_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    logic                 payload_valid;
    logic [BYTE_W-1:0]    payload_byte;
    status_t              frame_status;
    logic [LEN_W-1:0]     frame_length;
  } result_t;

  // Sum of two bytes reduced modulo 255.
  function automatic logic [BYTE_W-1:0] add_mod255(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    logic [BYTE_W:0] r;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {MOD_SUM, 1'b0}) begin
      r = s - {MOD_SUM, 1'b0};
    end else if (s >= {1'b0, MOD_SUM}) begin
      r = s - {1'b0, MOD_SUM};
    end else begin
      r = s;
    end
    return r[BYTE_W-1:0];
  endfunction

endpackage
`default_nettype wire

[src/mlcd_parser.sv]
// Frame parser: position tracking, length check and running Fletcher-16 sums.
`default_nettype none
module mlcd_parser
  import mlcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [BYTE_W-1:0]     data,
  input  wire logic [MAGIC_W-1:0]    magic_word,
  input  wire logic [LEN_W-1:0]      max_payload_len,
  output result_t                    result
);

  logic [POS_W-1:0]  position;
  logic [LEN_W-1:0]  payload_length;
  logic [BYTE_W-1:0] length_high;
  logic [BYTE_W-1:0] sum_low;
  logic [BYTE_W-1:0] sum_high;
  logic [BYTE_W-1:0] check_high;

  logic [POS_W-1:0]  position_next;
  logic [LEN_W-1:0]  payload_length_next;
  logic [BYTE_W-1:0] length_high_next;
  logic [BYTE_W-1:0] sum_low_next;
  logic [BYTE_W-1:0] sum_high_next;
  logic [BYTE_W-1:0] check_high_next;

  logic [15:0]       limit;
  logic [15:0]       rx_length;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  pos_inc;
  logic [CMP_W-1:0]  len_x;

  always_comb begin
    if (16'(MAX_PAYLOAD) < {7'd0, max_payload_len}) begin
      limit = 16'(MAX_PAYLOAD);
    end else begin
      limit = {7'd0, max_payload_len};
    end
  end

  assign rx_length = {length_high, data};
  assign pos_x = CMP_W'(position);
  assign pos_inc = pos_x + CMP_W'(1);
  assign len_x = CMP_W'(payload_length);

  always_comb begin
    position_next = position;
    payload_length_next = payload_length;
    length_high_next = length_high;
    sum_low_next = sum_low;
    sum_high_next = sum_high;
    check_high_next = check_high;
    result = '{payload_valid: 1'b0, payload_byte: '0, frame_status: STATUS_NONE,
               frame_length: '0};

    if (position == POS_W'(0)) begin
      if (data == magic_word[15:8]) begin
        position_next = POS_W'(1);
      end
    end else if (position == POS_W'(1)) begin
      position_next = (data == magic_word[7:0]) ? POS_W'(2) : POS_W'(0);
    end else if (position == POS_W'(2)) begin
      length_high_next = data;
      position_next = POS_W'(3);
    end else if (position == POS_W'(3)) begin
      if (rx_length > limit) begin
        position_next = POS_W'(0);
      end else begin
        payload_length_next = rx_length[LEN_W-1:0];
        sum_low_next = '0;
        sum_high_next = '0;
        position_next = POS_W'(HDR_BYTES);
      end
    end else if (pos_x < CMP_W'(BUFFER_BYTES)) begin
      if (pos_x < len_x + CMP_W'(HDR_BYTES)) begin
        sum_low_next = add_mod255(sum_low, data);
        sum_high_next = add_mod255(sum_high, sum_low_next);
        result.payload_valid = 1'b1;
        result.payload_byte = data;
      end else if (pos_x == len_x + CMP_W'(HDR_BYTES)) begin
        check_high_next = data;
      end
      if (pos_inc == len_x + CMP_W'(FRAME_OVERHEAD)) begin
        if (payload_length != '0 &&
            {check_high_next, data} == {sum_high_next, sum_low_next}) begin
          result.frame_status = STATUS_GOOD;
          result.frame_length = payload_length;
        end else begin
          result.frame_status = STATUS_REJECT;
        end
        position_next = POS_W'(0);
      end else begin
        position_next = pos_inc[POS_W-1:0];
      end
    end else begin
      position_next = POS_W'(0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      payload_length <= '0;
      length_high <= '0;
      sum_low <= '0;
      sum_high <= '0;
      check_high <= '0;
    end else if (step) begin
      position <= position_next;
      payload_length <= payload_length_next;
      length_high <= length_high_next;
      sum_low <= sum_low_next;
      sum_high <= sum_high_next;
      check_high <= check_high_next;
    end
  end

  a_position_bounded: assert property (@(posedge clk) disable iff (rst)
    position <= POS_W'(BUFFER_BYTES))
    else $error("Frame position ran past the buffer size.");

  a_good_has_length: assert property (@(posedge clk) disable iff (rst)
    (step && result.frame_status == STATUS_GOOD) |=>
      (position == POS_W'(0) && $past(payload_length) != '0))
    else $error("Good frame reported without a payload or without returning to hunt.");

  a_payload_not_end: assert property (@(posedge clk) disable iff (rst)
    (step && result.payload_valid) |-> (result.frame_status == STATUS_NONE &&
      position >= POS_W'(HDR_BYTES)))
    else $error("Payload byte reported outside the payload section.");

endmodule
`default_nettype wire

[src/mlcd_out_reg.sv]
// Result register that holds one result word until the receiver takes it.
`default_nettype none
module mlcd_out_reg
  import mlcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire result_t               result,
  output logic                       can_load,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       payload_valid,
  output logic [BYTE_W-1:0]          payload_byte,
  output logic [STATUS_W-1:0]        frame_status,
  output logic [LEN_W-1:0]           frame_length
);

  result_t held;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign payload_valid = held.payload_valid;
  assign payload_byte = held.payload_byte;
  assign frame_status = held.frame_status;
  assign frame_length = held.frame_length;

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("Loaded result word is not presented.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("Result word overwritten before it was taken.");

endmodule
`default_nettype wire

[src/magic_length_checksum_deframer.sv]
// Top level of the magic/length/checksum deframer with input stage and config registers.
//
// The input channel (in_valid, in_ready, rx_byte) takes one received byte per word.
// Every accepted byte produces exactly one result word on the output channel
// (out_valid, out_ready, payload_valid, payload_byte, frame_status, frame_length).
// The parser hunts for the two-byte magic word, reads a big-endian length, passes
// payload bytes out as they arrive and checks a big-endian Fletcher-16 at the end.
// An accepted byte first sits in the input register; the parser result for it is then
// loaded into the result register once that register can take it, raising out_valid.
// Throughput is one byte per cycle while the receiver does not stall; the parser
// step sets it, its state update and mod-255 adds completing between the two registers.
// When the receiver stalls, the result register holds its word, the input register
// fills, and in_ready drops; a word is taken in the same cycle the output drains.
// Reset clears the position to hunting, the sums to zero, the magic word to zero
// and the payload limit to 256; no clearing pass is needed.
// The config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 writes the magic word and index 1 the payload limit, other indexes are
// ignored. Write it only while the block is idle.
`default_nettype none
module magic_length_checksum_deframer
  import mlcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       payload_valid,
  output logic [BYTE_W-1:0]          payload_byte,
  output logic [STATUS_W-1:0]        frame_status,
  output logic [LEN_W-1:0]           frame_length,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MAGIC_W-1:0] magic_word;
  logic [LEN_W-1:0]   max_payload_len;

  logic               stage_valid;
  logic [BYTE_W-1:0]  stage_byte;
  logic               can_load;
  logic               step;
  result_t            result;

  assign cfg_ready = 1'b1;
  assign step = stage_valid && can_load;
  assign in_ready = !stage_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= '0;
      max_payload_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAGIC_WORD: magic_word <= cfg_data[MAGIC_W-1:0];
        CFG_MAX_LEN:    max_payload_len <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= rx_byte;
    end
  end

  mlcd_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .data            (stage_byte),
    .magic_word      (magic_word),
    .max_payload_len (max_payload_len),
    .result          (result)
  );

  mlcd_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (step),
    .result        (result),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .frame_status  (frame_status),
    .frame_length  (frame_length)
  );

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (stage_valid && out_valid))
    else $error("Input stalled while a stage was free.");

endmodule
`default_nettype wire
